// ===== hdl/bsc_pkg.sv =====
// Package: word types and fixed field widths for the bubble sort core.
`default_nettype none
package bsc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMP_W  = 10;
  localparam int unsigned SWP_W  = 9;

  localparam logic [CMP_W-1:0] CMP_MAX = {CMP_W{1'b1}};
  localparam logic [SWP_W-1:0] SWP_MAX = {SWP_W{1'b1}};

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     is_last_out;
    logic [CMP_W-1:0]         comparisons;
    logic [SWP_W-1:0]         swaps;
    logic                     overflow;
  } out_word_t;

endpackage
`default_nettype wire

// ===== hdl/bubble_sort_with_cost_count_core.sv =====
// Top level: buffered early-exit bubble sort with comparison and swap counts.
//
//  channel | dir | handshake           | word
//  --------+-----+---------------------+--------------------------------------------
//  in      | in  | in_valid / in_stall | value, is_last
//  out     | out | out_valid/out_stall | sorted_value, is_last_out, comparisons,
//          |     |                     | swaps, overflow
//
// Load: one word per cycle into the element memory; in_stall is high outside load.
// Sort: one compare per S_PSTEP cycle; a pass runs S_PSTART, S_PFIRST, the steps
//   and S_PEND, and passes repeat until one makes no swap.
// Emit: S_ERD reads and S_ELD loads each word through the single memory read port.
// Reset (rst_n low, synchronous) clears counts and flags; no memory clearing.
// A stalled output holds the word; the next sequence loads while it waits.
`default_nettype none
module bubble_sort_with_cost_count_core #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire bsc_pkg::in_word_t in_data,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      bsc_pkg::out_word_t out_data
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_PSTART = 3'd1;
  localparam logic [2:0] S_PFIRST = 3'd2;
  localparam logic [2:0] S_PSTEP  = 3'd3;
  localparam logic [2:0] S_PEND   = 3'd4;
  localparam logic [2:0] S_ERD    = 3'd5;
  localparam logic [2:0] S_ELD    = 3'd6;

  logic signed [bsc_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [bsc_pkg::DATA_W-1:0] rd_r;
  logic signed [bsc_pkg::DATA_W-1:0] carry_r, carry_nxt;

  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic [bsc_pkg::CMP_W-1:0] cmp_r, cmp_nxt;
  logic [bsc_pkg::SWP_W-1:0] swp_r, swp_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    swapped_r, swapped_nxt;
  logic                    out_valid_r, out_valid_nxt;
  bsc_pkg::out_word_t      out_r, out_nxt;

  logic                    mem_we;
  logic [IW-1:0]           mem_wa, mem_ra;
  logic signed [bsc_pkg::DATA_W-1:0] mem_wd;

  logic          in_acc, out_acc, do_swap, at_end;
  logic [CW-1:0] cnt_inc, last_pos;

  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_acc   = out_valid_r && !out_stall;
  assign out_data  = out_r;

  assign do_swap  = carry_r > rd_r;
  assign last_pos = cnt_r - CW'(1);
  assign at_end   = (CW'(idx_r) == last_pos);
  assign cnt_inc  = (cnt_r < CW'(DEPTH)) ? cnt_r + CW'(1) : cnt_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    cmp_nxt       = cmp_r;
    swp_nxt       = swp_r;
    ovf_nxt       = ovf_r;
    swapped_nxt   = swapped_r;
    carry_nxt     = carry_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_acc;
    mem_we        = 1'b0;
    mem_wa        = cnt_r[IW-1:0];
    mem_wd        = in_data.value;
    mem_ra        = idx_r;
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CW'(DEPTH)) begin
            mem_we = 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          cnt_nxt = cnt_inc;
          if (in_data.is_last) begin
            idx_nxt   = '0;
            state_nxt = (cnt_inc > CW'(1)) ? S_PSTART : S_ERD;
          end
        end
      end
      S_PSTART: begin
        mem_ra      = '0;
        idx_nxt     = IW'(1);
        swapped_nxt = 1'b0;
        state_nxt   = S_PFIRST;
      end
      S_PFIRST: begin
        carry_nxt = rd_r;
        mem_ra    = idx_r;
        state_nxt = S_PSTEP;
      end
      S_PSTEP: begin
        mem_ra = IW'(idx_r + IW'(1));
        mem_we = 1'b1;
        mem_wa = IW'(idx_r - IW'(1));
        if (cmp_r != bsc_pkg::CMP_MAX) cmp_nxt = cmp_r + 1'b1;
        if (do_swap) begin
          mem_wd      = rd_r;
          swapped_nxt = 1'b1;
          if (swp_r != bsc_pkg::SWP_MAX) swp_nxt = swp_r + 1'b1;
        end else begin
          mem_wd    = carry_r;
          carry_nxt = rd_r;
        end
        if (at_end) begin
          state_nxt = S_PEND;
        end else begin
          idx_nxt = IW'(idx_r + IW'(1));
        end
      end
      S_PEND: begin
        mem_we    = 1'b1;
        mem_wa    = last_pos[IW-1:0];
        mem_wd    = carry_r;
        idx_nxt   = '0;
        state_nxt = swapped_r ? S_PSTART : S_ERD;
      end
      S_ERD: begin
        mem_ra = idx_r;
        if (!out_valid_r || !out_stall) state_nxt = S_ELD;
      end
      S_ELD: begin
        out_valid_nxt        = 1'b1;
        out_nxt.sorted_value = rd_r;
        out_nxt.is_last_out  = at_end;
        out_nxt.comparisons  = cmp_r;
        out_nxt.swaps        = swp_r;
        out_nxt.overflow     = ovf_r;
        if (at_end) begin
          cnt_nxt   = '0;
          cmp_nxt   = '0;
          swp_nxt   = '0;
          ovf_nxt   = 1'b0;
          idx_nxt   = '0;
          state_nxt = S_LOAD;
        end else begin
          idx_nxt   = IW'(idx_r + IW'(1));
          state_nxt = S_ERD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      idx_r       <= '0;
      cmp_r       <= '0;
      swp_r       <= '0;
      ovf_r       <= 1'b0;
      swapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      cmp_r       <= cmp_nxt;
      swp_r       <= swp_nxt;
      ovf_r       <= ovf_nxt;
      swapped_r   <= swapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    out_r   <= out_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_sort_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PSTART || state_r == S_PFIRST || state_r == S_PSTEP ||
     state_r == S_PEND) |-> cnt_r >= CW'(2))
    else $error("sort running on fewer than two elements");

  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != S_LOAD) |-> CW'(mem_wa) < cnt_r)
    else $error("sort write beyond stored elements");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ELD) |-> !out_valid_r)
    else $error("result word overwritten while pending");

  a_swp_le_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (cmp_r != bsc_pkg::CMP_MAX) |-> bsc_pkg::CMP_W'(swp_r) <= cmp_r)
    else $error("swap count above comparison count");

endmodule
`default_nettype wire
